// ===== rtl/vector_distance_euclid_cosine_top_defines.svh =====
// Assertion macros shared by the vector distance RTL.
// Each macro expects clk and rst to be in scope at the point of use.
`ifndef VECTOR_DISTANCE_EUCLID_COSINE_TOP_DEFINES_SVH
`define VECTOR_DISTANCE_EUCLID_COSINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VDEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define VDEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vdec_pkg.sv =====
// Package for the vector distance block: widths, codes, control structs.
// No dependencies; used by vdec_mul, vdec_iter and the top level through scoped names.
package vdec_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int SUM_W      = 48;
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CHUNK_W    = 24;
  localparam int RAD_W      = 2 * SUM_W;
  localparam int REM_W      = SUM_W + 3;
  localparam int DIST_W     = 37;
  localparam int Q_W        = 17;
  localparam int ROOT_STEPS = SUM_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int STEP_CNT_W = 6;
  localparam int PHASE_LAST = 4;

  localparam logic [DIST_W-1:0] ONE_Q16  = DIST_W'(65536);
  localparam logic [DIST_W-1:0] TWO_Q16  = DIST_W'(131072);
  localparam logic [Q_W-1:0]    Q_ONE    = Q_W'(65536);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_FIN, ST_NPROD, ST_SQST, ST_ROOT, ST_CHK, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

  // Sign-extend the low ELEM_WIDTH bits of an element to the multiplier width.
  function automatic logic signed [MUL_W-1:0] sext_elem(input logic [15:0] x);
    return $signed({{(MUL_W - ELEM_WIDTH){x[ELEM_WIDTH-1]}}, x[ELEM_WIDTH-1:0]});
  endfunction

endpackage

// ===== rtl/vdec_in_if.sv =====
// Input channel: one element pair per transaction.
// Depends on nothing.
interface vdec_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_value;
  logic signed [15:0] b_value;
  logic               last_pair;

  modport source (output valid, a_value, b_value, last_pair, input ready);
  modport sink   (input valid, a_value, b_value, last_pair, output ready);
endinterface

// ===== rtl/vdec_out_if.sv =====
// Output channel: one distance result per transaction.
// Depends on nothing.
interface vdec_out_if;
  logic        valid;
  logic        ready;
  logic [36:0] distance;
  logic        zero_norm;

  modport source (output valid, distance, zero_norm, input ready);
  modport sink   (input valid, distance, zero_norm, output ready);
endinterface

// ===== rtl/vdec_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on vdec_pkg.
module vdec_mul (
  input  logic                                 clk,
  input  logic signed [vdec_pkg::MUL_W-1:0]    x,
  input  logic signed [vdec_pkg::MUL_W-1:0]    y,
  output logic signed [vdec_pkg::PROD_W-1:0]   p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= x * y;
  end

endmodule

// ===== rtl/vdec_iter.sv =====
// Iterative root and divide engine around one shared compare-subtract unit.
// Depends on vdec_pkg and the assertion macro header.
`include "vector_distance_euclid_cosine_top_defines.svh"

module vdec_iter (
  input  logic                              clk,
  input  logic                              rst,
  input  vdec_pkg::iter_ctl_t               ctl,
  input  logic [vdec_pkg::RAD_W-1:0]        radicand,
  input  logic [vdec_pkg::SUM_W-1:0]        dividend,
  input  logic [vdec_pkg::SUM_W-1:0]        divisor,
  output vdec_pkg::iter_sts_t               sts,
  output logic [vdec_pkg::SUM_W-1:0]        result
);

  logic                              active;
  logic                              done;
  vdec_pkg::op_t                     op_q;
  logic [vdec_pkg::STEP_CNT_W-1:0]   cnt;
  logic [vdec_pkg::RAD_W-1:0]        rad;
  logic [vdec_pkg::REM_W-1:0]        rem;
  logic [vdec_pkg::SUM_W-1:0]        res;

  logic [vdec_pkg::REM_W-1:0]        rem_sh;
  logic [vdec_pkg::REM_W-1:0]        trial;
  logic [vdec_pkg::REM_W-1:0]        diff;
  logic [vdec_pkg::REM_W-1:0]        rem_sel;
  logic                              ge;

  // Pick the operands of the shared compare-subtract for this step
  always_comb begin
    if (op_q == vdec_pkg::OP_SQRT) begin
      rem_sh = {rem[vdec_pkg::REM_W-3:0], rad[vdec_pkg::RAD_W-1 -: 2]};
      trial  = {1'b0, res, 2'b01};
    end else begin
      rem_sh = rem;
      trial  = {3'b000, divisor};
    end
    ge      = (rem_sh >= trial);
    diff    = rem_sh - trial;
    rem_sel = ge ? diff : rem_sh;
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      op_q   <= vdec_pkg::OP_SQRT;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        active <= 1'b1;
        op_q   <= ctl.op;
        cnt    <= (ctl.op == vdec_pkg::OP_SQRT) ?
                  vdec_pkg::STEP_CNT_W'(vdec_pkg::ROOT_STEPS) :
                  vdec_pkg::STEP_CNT_W'(vdec_pkg::DIV_STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == vdec_pkg::STEP_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one bit per step
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rad <= radicand;
      res <= '0;
      rem <= (ctl.op == vdec_pkg::OP_SQRT) ? '0 : {3'b000, dividend};
    end else if (active) begin
      rad <= {rad[vdec_pkg::RAD_W-3:0], 2'b00};
      res <= {res[vdec_pkg::SUM_W-2:0], ge};
      rem <= (op_q == vdec_pkg::OP_SQRT) ? rem_sel :
             {rem_sel[vdec_pkg::REM_W-2:0], 1'b0};
    end
  end

  assign sts.busy = active;
  assign sts.done = done;
  assign result   = res;

  `VDEC_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `VDEC_ASSERT_NEXT(a_start_busy, ctl.start, active, "engine not busy after start")
  `VDEC_ASSERT_NOW(a_quot_width, done && (op_q == vdec_pkg::OP_DIV),
    res[vdec_pkg::SUM_W-1:vdec_pkg::Q_W] == '0, "quotient wider than 17 bits")

endmodule

// ===== rtl/vector_distance_euclid_cosine_top.sv =====
// Top level of the vector distance block: sequencer, sums, result register.
// Depends on vdec_pkg, vdec_in_if, vdec_out_if, vdec_mul, vdec_iter, macro header.
//
//   channel   dir  payload                          handshake
//   in_ch     in   a_value, b_value, last_pair       valid/ready
//   out_ch    out  distance (Q21.16), zero_norm      valid/ready
//   cfg       in   cfg_wdata (distance_mode)         cfg_we, no wait
//
// Each pair runs as: accept, then four passes through the one multiplier plus a
// trailing accumulate. A last pair then runs the 48-step root (Euclidean mode) or the
// norm product, root and, if needed, 17-step divide (cosine mode, nonzero norms).
// Reset (rst, synchronous) clears the sums and the mode. in_ch.ready is high only
// between items; a waiting result is held in the output register while the next
// vector streams in, and a new result waits until that register is free.
`include "vector_distance_euclid_cosine_top_defines.svh"

module vector_distance_euclid_cosine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  vdec_in_if.sink     in_ch,
  vdec_out_if.source  out_ch
);

  vdec_pkg::state_t                        state;
  vdec_pkg::state_t                        state_next;
  logic [2:0]                              cnt;
  logic                                    mode;
  logic signed [vdec_pkg::MUL_W-1:0]       a_q;
  logic signed [vdec_pkg::MUL_W-1:0]       b_q;
  logic                                    last_q;
  logic [vdec_pkg::SUM_W-1:0]              dd;
  logic [vdec_pkg::SUM_W-1:0]              dot;
  logic [vdec_pkg::SUM_W-1:0]              na;
  logic [vdec_pkg::SUM_W-1:0]              nb;
  logic [vdec_pkg::RAD_W-1:0]              prod_acc;
  logic [vdec_pkg::SUM_W-1:0]              s_root;
  logic [vdec_pkg::DIST_W-1:0]             dist_r;
  logic                                    zn_r;
  logic                                    ovalid;
  logic [vdec_pkg::DIST_W-1:0]             odist;
  logic                                    ozn;

  logic signed [vdec_pkg::MUL_W-1:0]       mul_x;
  logic signed [vdec_pkg::MUL_W-1:0]       mul_y;
  logic signed [vdec_pkg::PROD_W-1:0]      prod;
  vdec_pkg::iter_ctl_t                     ictl;
  vdec_pkg::iter_sts_t                     ists;
  logic [vdec_pkg::RAD_W-1:0]              radicand;
  logic [vdec_pkg::SUM_W-1:0]              iresult;
  logic [vdec_pkg::SUM_W-1:0]              mag;
  logic                                    neg;
  logic                                    out_load;
  logic [vdec_pkg::SUM_W-1:0]              acc_cur;
  logic [vdec_pkg::SUM_W:0]                acc_sum;
  logic [vdec_pkg::SUM_W-1:0]              acc_sat;
  logic                                    acc_signed;
  logic [vdec_pkg::Q_W-1:0]                q_clamp;

  // Shared multiplier
  vdec_mul u_mul (
    .clk (clk),
    .x   (mul_x),
    .y   (mul_y),
    .p   (prod)
  );

  // Shared root and divide engine
  vdec_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ictl),
    .radicand (radicand),
    .dividend (mag),
    .divisor  (s_root),
    .sts      (ists),
    .result   (iresult)
  );

  assign neg      = dot[vdec_pkg::SUM_W-1];
  assign mag      = neg ? (~dot + 1'b1) : dot;
  assign radicand = mode ? prod_acc : {16'h0000, dd, 32'h0000_0000};

  // Saturating accumulate of the product issued in the cycle before
  always_comb begin
    case (cnt)
      3'd1:    acc_cur = dd;
      3'd2:    acc_cur = dot;
      3'd3:    acc_cur = na;
      default: acc_cur = nb;
    endcase
    acc_signed = (cnt == 3'd2);
    acc_sum = (acc_signed ? {acc_cur[vdec_pkg::SUM_W-1], acc_cur} : {1'b0, acc_cur})
              + prod[vdec_pkg::SUM_W:0];
    if (acc_signed) begin
      if (acc_sum[vdec_pkg::SUM_W] != acc_sum[vdec_pkg::SUM_W-1]) begin
        acc_sat = acc_sum[vdec_pkg::SUM_W] ? {1'b1, {(vdec_pkg::SUM_W-1){1'b0}}} :
                                              {1'b0, {(vdec_pkg::SUM_W-1){1'b1}}};
      end else begin
        acc_sat = acc_sum[vdec_pkg::SUM_W-1:0];
      end
    end else begin
      acc_sat = acc_sum[vdec_pkg::SUM_W] ? {vdec_pkg::SUM_W{1'b1}} :
                                           acc_sum[vdec_pkg::SUM_W-1:0];
    end
  end

  // Clamp the quotient to one
  assign q_clamp = (iresult[vdec_pkg::Q_W-1:0] > vdec_pkg::Q_ONE) ? vdec_pkg::Q_ONE :
                   iresult[vdec_pkg::Q_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    mul_x      = a_q - b_q;
    mul_y      = a_q - b_q;
    ictl.start = 1'b0;
    ictl.op    = vdec_pkg::OP_SQRT;
    out_load   = 1'b0;
    case (state)
      vdec_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = vdec_pkg::ST_ACC;
      end
      vdec_pkg::ST_ACC: begin
        case (cnt)
          3'd1:    begin mul_x = a_q; mul_y = b_q; end
          3'd2:    begin mul_x = a_q; mul_y = a_q; end
          3'd3:    begin mul_x = b_q; mul_y = b_q; end
          default: begin mul_x = a_q - b_q; mul_y = a_q - b_q; end
        endcase
        if (cnt == 3'(vdec_pkg::PHASE_LAST)) begin
          state_next = last_q ? vdec_pkg::ST_FIN : vdec_pkg::ST_IDLE;
        end
      end
      vdec_pkg::ST_FIN: begin
        if (!mode) state_next = vdec_pkg::ST_SQST;
        else if (na == '0 || nb == '0) state_next = vdec_pkg::ST_OUT;
        else state_next = vdec_pkg::ST_NPROD;
      end
      vdec_pkg::ST_NPROD: begin
        case (cnt)
          3'd1: begin
            mul_x = $signed({1'b0, na[vdec_pkg::SUM_W-1 -: vdec_pkg::CHUNK_W]});
            mul_y = $signed({1'b0, nb[vdec_pkg::CHUNK_W-1:0]});
          end
          3'd2: begin
            mul_x = $signed({1'b0, na[vdec_pkg::CHUNK_W-1:0]});
            mul_y = $signed({1'b0, nb[vdec_pkg::SUM_W-1 -: vdec_pkg::CHUNK_W]});
          end
          3'd3: begin
            mul_x = $signed({1'b0, na[vdec_pkg::SUM_W-1 -: vdec_pkg::CHUNK_W]});
            mul_y = $signed({1'b0, nb[vdec_pkg::SUM_W-1 -: vdec_pkg::CHUNK_W]});
          end
          default: begin
            mul_x = $signed({1'b0, na[vdec_pkg::CHUNK_W-1:0]});
            mul_y = $signed({1'b0, nb[vdec_pkg::CHUNK_W-1:0]});
          end
        endcase
        if (cnt == 3'(vdec_pkg::PHASE_LAST)) state_next = vdec_pkg::ST_SQST;
      end
      vdec_pkg::ST_SQST: begin
        ictl.start = 1'b1;
        state_next = vdec_pkg::ST_ROOT;
      end
      vdec_pkg::ST_ROOT: begin
        if (ists.done) state_next = mode ? vdec_pkg::ST_CHK : vdec_pkg::ST_OUT;
      end
      vdec_pkg::ST_CHK: begin
        // Twice a root with its top bit set is above any dot magnitude: always divide
        if (!s_root[vdec_pkg::SUM_W-1] &&
            (mag >= {s_root[vdec_pkg::SUM_W-2:0], 1'b0})) begin
          state_next = vdec_pkg::ST_OUT;
        end else begin
          ictl.start = 1'b1;
          ictl.op    = vdec_pkg::OP_DIV;
          state_next = vdec_pkg::ST_DIV;
        end
      end
      vdec_pkg::ST_DIV: begin
        if (ists.done) state_next = vdec_pkg::ST_OUT;
      end
      vdec_pkg::ST_OUT: begin
        if (!ovalid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = vdec_pkg::ST_IDLE;
        end
      end
      default: state_next = vdec_pkg::ST_IDLE;
    endcase
  end

  // Phase counter and mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      mode <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (state == vdec_pkg::ST_ACC || state == vdec_pkg::ST_NPROD) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

  // Running sums: accumulate, and clear once the result is loaded
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      dd  <= '0;
      dot <= '0;
      na  <= '0;
      nb  <= '0;
    end else if (state == vdec_pkg::ST_ACC) begin
      case (cnt)
        3'd1:    dd  <= acc_sat;
        3'd2:    dot <= acc_sat;
        3'd3:    na  <= acc_sat;
        3'd4:    nb  <= acc_sat;
        default: ;
      endcase
    end
  end

  // Item capture, norm product, root and result staging
  always_ff @(posedge clk) begin
    if (state == vdec_pkg::ST_IDLE && in_ch.valid) begin
      a_q    <= vdec_pkg::sext_elem(in_ch.a_value);
      b_q    <= vdec_pkg::sext_elem(in_ch.b_value);
      last_q <= in_ch.last_pair;
    end
    case (state)
      vdec_pkg::ST_FIN: begin
        prod_acc <= '0;
        dist_r   <= vdec_pkg::ONE_Q16;
        zn_r     <= mode;
      end
      vdec_pkg::ST_NPROD: begin
        case (cnt)
          3'd1:    prod_acc <= prod_acc + vdec_pkg::RAD_W'(prod[vdec_pkg::SUM_W-1:0]);
          3'd2,
          3'd3:    prod_acc <= prod_acc +
                               (vdec_pkg::RAD_W'(prod[vdec_pkg::SUM_W-1:0]) << 24);
          3'd4:    prod_acc <= prod_acc +
                               (vdec_pkg::RAD_W'(prod[vdec_pkg::SUM_W-1:0]) << 48);
          default: ;
        endcase
      end
      vdec_pkg::ST_ROOT: begin
        zn_r   <= 1'b0;
        s_root <= iresult;
        dist_r <= (iresult[vdec_pkg::SUM_W-1:vdec_pkg::DIST_W] != '0) ?
                  vdec_pkg::DIST_MAX : iresult[vdec_pkg::DIST_W-1:0];
      end
      vdec_pkg::ST_CHK: begin
        dist_r <= neg ? vdec_pkg::TWO_Q16 : '0;
      end
      vdec_pkg::ST_DIV: begin
        dist_r <= neg ? vdec_pkg::ONE_Q16 + vdec_pkg::DIST_W'(q_clamp) :
                        vdec_pkg::ONE_Q16 - vdec_pkg::DIST_W'(q_clamp);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odist <= dist_r;
      ozn   <= zn_r;
    end
  end

  assign in_ch.ready      = (state == vdec_pkg::ST_IDLE);
  assign out_ch.valid     = ovalid;
  assign out_ch.distance  = odist;
  assign out_ch.zero_norm = ozn;

  `VDEC_ASSERT_NOW(a_start_idle, ictl.start, !ists.busy, "engine started while busy")
  `VDEC_ASSERT_NOW(a_zn_one, out_ch.valid && out_ch.zero_norm,
    out_ch.distance == vdec_pkg::ONE_Q16, "zero norm result is not one")
  `VDEC_ASSERT_NEXT(a_busy_after, in_ch.valid && in_ch.ready, !in_ch.ready,
    "ready high right after accepting a pair")

endmodule
